// ----- rtl/running_mean_variance_macros.svh -----
// Assertion macros for the running mean and variance block.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef RUNNING_MEAN_VARIANCE_MACROS_SVH
`define RUNNING_MEAN_VARIANCE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define RMV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define RMV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rmv_pkg.sv -----
// Package for the running mean and variance block: widths and types.
// No dependencies.
`default_nettype none

package rmv_pkg;

    localparam int COUNT_BITS = 32;
    localparam int SAMPLE_W   = 32;
    localparam int OUT_CNT_W  = 32;
    localparam int VAR_W      = 62;
    // quotient of the mean step: |x - m| + half rounds to at most 2^32
    localparam int Q_W        = 33;
    // numerator bound: n*(v + dm^2) + dx^2 + half < 2^(COUNT_BITS + 65)
    localparam int ACC_W      = COUNT_BITS + 65;
    localparam int ADD_W      = ACC_W + 1;
    localparam int REM_W      = COUNT_BITS + 2;
    localparam int DIV1_W     = ((COUNT_BITS > Q_W) ? COUNT_BITS : Q_W) + 1;
    localparam int MPL_W      = (COUNT_BITS > Q_W) ? COUNT_BITS : Q_W;
    localparam int ITER_W     = $clog2(ACC_W);

    localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

    typedef logic [ACC_W-1:0]      t_acc;
    typedef logic [ADD_W-1:0]      t_add;
    typedef logic [COUNT_BITS-1:0] t_count;

endpackage

`default_nettype wire

// ----- rtl/running_mean_variance.sv -----
// Running mean and population variance (online update), fixed point, one sample per word.
// A new word is taken only after the last result is committed; the work is done by two
// bit-serial divisions and three shift-add products sharing one 98-bit adder.
// Synchronous active-low reset clears count, mean and variance.
// Depends on rmv_pkg and running_mean_variance_macros.svh.
`default_nettype none

`include "running_mean_variance_macros.svh"

module running_mean_variance (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire  [rmv_pkg::SAMPLE_W-1:0] i_sample,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [rmv_pkg::OUT_CNT_W-1:0] o_sample_count,
    output logic [rmv_pkg::SAMPLE_W-1:0] o_running_mean,
    output logic [rmv_pkg::VAR_W-1:0]    o_running_variance
);

    import rmv_pkg::*;

    // Sequencer. Every working state drives the one shared adder.
    localparam logic [3:0] S_IDLE  = 4'd0;  // wait for a word
    localparam logic [3:0] S_DIFF  = 4'd1;  // x - m
    localparam logic [3:0] S_ABS   = 4'd2;  // |x - m| + half, preload divider
    localparam logic [3:0] S_DIV1  = 4'd3;  // mean step quotient, one bit a cycle
    localparam logic [3:0] S_MEAN  = 4'd4;  // m' = m +/- q
    localparam logic [3:0] S_DX    = 4'd5;  // x - m'
    localparam logic [3:0] S_DXABS = 4'd6;  // |x - m'|, start dm * dm
    localparam logic [3:0] S_SQ1   = 4'd7;  // dm^2, shift-add
    localparam logic [3:0] S_ADDV  = 4'd8;  // v + dm^2, start n * (...)
    localparam logic [3:0] S_MULN  = 4'd9;  // half + n*(v + dm^2)
    localparam logic [3:0] S_SQ2   = 4'd10; // + dx^2
    localparam logic [3:0] S_DIV2  = 4'd11; // variance quotient, one bit a cycle
    localparam logic [3:0] S_DONE  = 4'd12; // commit state, present result

    logic [3:0]            r_state, n_state;
    logic [ITER_W-1:0]     r_cnt;
    logic                  r_out_valid;

    // running state
    t_count                r_count;
    logic [SAMPLE_W-1:0]   r_mean;
    logic [VAR_W-1:0]      r_var;

    // working registers
    logic [SAMPLE_W-1:0]   r_x;
    logic                  r_neg;
    t_acc                  r_acc;
    t_acc                  r_mcand;
    logic [MPL_W-1:0]      r_mplier;
    logic [REM_W-1:0]      r_rem;
    logic [Q_W-1:0]        r_dm;
    logic [Q_W-1:0]        r_dx;

    // shared adder
    t_add                  add_a, add_b, add_sum;
    logic                  add_cin;

    logic [COUNT_BITS:0]   d;
    t_count                half;
    t_count                n_count;
    logic [REM_W-1:0]      div_shift;
    logic                  trial_ok;
    logic                  iter_last;
    logic                  out_free;
    logic [63:0]           cnt_ext;
    logic [VAR_W-1:0]      var_sat;

    // Divisor d = n + 1; the count never passes its maximum, so d fits COUNT_BITS + 1.
    assign d    = {1'b0, r_count} + 1'b1;
    assign half = d[COUNT_BITS:1];
    // Hold the count once it reaches all ones.
    assign n_count = (&r_count) ? r_count : d[COUNT_BITS-1:0];

    assign div_shift = {r_rem[REM_W-2:0], r_acc[ACC_W-1]};
    assign trial_ok  = !add_sum[ADD_W-1];
    assign iter_last = (r_cnt == '0);
    assign out_free  = !r_out_valid || !i_out_stall;

    // Operand selection for the shared adder.
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        case (r_state)
            S_DIFF, S_DX: begin
                add_a   = ADD_W'(signed'(r_x));
                add_b   = ~ADD_W'(signed'(r_mean));
                add_cin = 1'b1;
            end
            S_ABS: begin
                add_a   = r_neg ? ADD_W'(~r_acc) : ADD_W'(r_acc);
                add_b   = ADD_W'(half);
                add_cin = r_neg;
            end
            S_DXABS: begin
                add_a   = r_neg ? ADD_W'(~r_acc) : ADD_W'(r_acc);
                add_cin = r_neg;
            end
            S_DIV1, S_DIV2: begin
                // trial subtract of the divisor from the shifted remainder
                add_a   = ADD_W'(div_shift);
                add_b   = ~ADD_W'(d);
                add_cin = 1'b1;
            end
            S_MEAN: begin
                add_a   = ADD_W'(signed'(r_mean));
                add_b   = r_neg ? ~ADD_W'(r_acc[Q_W-1:0]) : ADD_W'(r_acc[Q_W-1:0]);
                add_cin = r_neg;
            end
            S_SQ1, S_MULN, S_SQ2: begin
                add_a   = ADD_W'(r_acc);
                add_b   = r_mplier[0] ? ADD_W'(r_mcand) : '0;
            end
            S_ADDV: begin
                add_a   = ADD_W'(r_acc);
                add_b   = ADD_W'(r_var);
            end
            default: begin
                add_a   = '0;
            end
        endcase
    end

    assign add_sum = add_a + add_b + ADD_W'(add_cin);

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_DIFF;
            S_DIFF:  n_state = S_ABS;
            S_ABS:   n_state = S_DIV1;
            S_DIV1:  if (iter_last) n_state = S_MEAN;
            S_MEAN:  n_state = S_DX;
            S_DX:    n_state = S_DXABS;
            S_DXABS: n_state = S_SQ1;
            S_SQ1:   if (iter_last) n_state = S_ADDV;
            S_ADDV:  n_state = S_MULN;
            S_MULN:  if (iter_last) n_state = S_SQ2;
            S_SQ2:   if (iter_last) n_state = S_DIV2;
            S_DIV2:  if (iter_last) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Take a new word only between items; a waiting result does not block this.
    assign o_in_stall = (r_state != S_IDLE);

    // Result formatting: saturate variance quotient and the reported count.
    assign var_sat = (|r_acc[ACC_W-1:VAR_W]) ? VAR_MAX : r_acc[VAR_W-1:0];
    assign cnt_ext = 64'(n_count);

    // Control and running state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_mean      <= '0;
            r_var       <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_MEAN) begin
                r_mean <= add_sum[SAMPLE_W-1:0];
            end
            if (r_state == S_DONE && out_free) begin
                r_var       <= var_sat;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath and output word.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_x <= i_sample;
            end
            S_DIFF, S_DX: begin
                r_acc <= add_sum[ACC_W-1:0];
                r_neg <= add_sum[ADD_W-1];
            end
            S_ABS: begin
                // left-align the numerator so the divider walks its top bits only
                r_acc <= ACC_W'(add_sum[DIV1_W-1:0]) << (ACC_W - DIV1_W);
                r_rem <= '0;
                r_cnt <= ITER_W'(DIV1_W - 1);
            end
            S_DIV1, S_DIV2: begin
                r_rem <= trial_ok ? add_sum[REM_W-1:0] : div_shift;
                r_acc <= {r_acc[ACC_W-2:0], trial_ok};
                r_cnt <= r_cnt - 1'b1;
            end
            S_MEAN: begin
                // |m - m'| is the rounded quotient itself
                r_dm <= r_acc[Q_W-1:0];
            end
            S_DXABS: begin
                r_dx     <= add_sum[Q_W-1:0];
                r_acc    <= '0;
                r_mcand  <= ACC_W'(r_dm);
                r_mplier <= MPL_W'(r_dm);
                r_cnt    <= ITER_W'(Q_W - 1);
            end
            S_SQ1, S_MULN, S_SQ2: begin
                r_acc <= add_sum[ACC_W-1:0];
                if (iter_last && r_state == S_MULN) begin
                    // chain straight into dx * dx on the same accumulator
                    r_mcand  <= ACC_W'(r_dx);
                    r_mplier <= MPL_W'(r_dx);
                    r_cnt    <= ITER_W'(Q_W - 1);
                end else if (iter_last && r_state == S_SQ2) begin
                    r_rem <= '0;
                    r_cnt <= ITER_W'(ACC_W - 1);
                end else begin
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt - 1'b1;
                end
            end
            S_ADDV: begin
                // seed the accumulator with the rounding half of d
                r_mcand  <= add_sum[ACC_W-1:0];
                r_mplier <= MPL_W'(r_count);
                r_acc    <= ACC_W'(half);
                r_cnt    <= ITER_W'(COUNT_BITS - 1);
            end
            S_DONE: begin
                if (out_free) begin
                    o_sample_count     <= (|cnt_ext[63:OUT_CNT_W]) ?
                                          {OUT_CNT_W{1'b1}} : cnt_ext[OUT_CNT_W-1:0];
                    o_running_mean     <= r_mean;
                    o_running_variance <= var_sat;
                end
            end
            default: begin
                r_neg <= r_neg;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    // Checks on the sequencer and divider.
    `RMV_ASSERT_NEXT(a_accept_starts, i_in_valid && !o_in_stall, r_state == S_DIFF, "no start")
    `RMV_ASSERT_NOW(a_rem_below_d, r_state == S_DIV1 || r_state == S_DIV2, r_rem < d, "rem >= d")
    `RMV_ASSERT_NOW(a_count_nonzero, r_out_valid, r_count != '0, "zero count")

endmodule

`default_nettype wire
